FILE: rtl/ufs_pkg.sv
// Shared widths, request codes and controller/datapath interface types for the union-find block.
package ufs_pkg;

  localparam int ID_W          = 10;
  localparam int SIZE_W        = 11;
  localparam int CNT_W         = 11;
  localparam int EXT_W         = 17;
  localparam int MAX_NODES_DEF = 1024;
  localparam int IN_DATA_W     = 24;
  localparam int OUT_DATA_W    = 24;
  localparam logic [CNT_W-1:0] NODE_COUNT_RST = CNT_W'(1024);

  localparam logic REQ_MERGE = 1'b0;
  localparam logic REQ_FIND  = 1'b1;

  typedef struct packed {
    logic clr_step;
    logic accept;
    logic walk_next;
    logic walk_done;
    logic cmp_read;
    logic cmp_write;
    logic start_b;
    logic save_ra;
    logic save_rb;
    logic sz_rd_a;
    logic sz_rd_b;
    logic sz_fin;
    logic out_load;
  } ufs_cmd_t;

  typedef struct packed {
    logic in_err;
    logic is_merge;
    logic walk_root;
    logic cmp_at_root;
    logic clr_last;
    logic out_free;
  } ufs_sts_t;

endpackage

FILE: rtl/ufs_dp.sv
// Datapath: parent and size memories, walk registers, merge arithmetic and output register.
module ufs_dp #(
  parameter int MAX_NODES = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ufs_pkg::ufs_cmd_t                   cmd,
  output ufs_pkg::ufs_sts_t                   sts,
  input  logic                                in_tuser,
  input  logic [ufs_pkg::IN_DATA_W-1:0]       in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ufs_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [ufs_pkg::CNT_W-1:0]           cfg_data
);
  import ufs_pkg::*;

  localparam int IDW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam logic [EXT_W-1:0] MAX_L   = EXT_W'(MAX_NODES);
  localparam logic [IDW-1:0]   MAX_IDX = IDW'(MAX_NODES - 1);

  logic [IDW-1:0]    par_mem [MAX_NODES];
  logic [SIZE_W-1:0] sz_mem  [MAX_NODES];

  logic [CNT_W-1:0]  node_count_r;
  logic [IDW-1:0]    clr_cnt_r;
  logic [IDW-1:0]    cur_r, start_r, root_r, ra_r, rb_r, b_r;
  logic [IDW-1:0]    par_q_r;
  logic [SIZE_W-1:0] sz_q_r, size_a_r;
  logic              is_merge_r;
  logic [ID_W-1:0]   res_root_r;
  logic [SIZE_W-1:0] res_size_r;
  logic              res_joined_r, res_err_r;
  logic              out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [ID_W-1:0]   in_a, in_b;
  logic [EXT_W-1:0]  lim, a_ext, b_ext;
  logic              in_err;
  logic [IDW-1:0]    a_idx, b_idx;

  logic              par_rd_en, par_wr_en, sz_rd_en, sz_wr_en;
  logic [IDW-1:0]    par_rd_addr, par_wr_addr, par_wr_data, sz_rd_addr, sz_wr_addr;
  logic [SIZE_W-1:0] sz_wr_data, sum;
  logic              same, a_gt;
  logic [ID_W-1:0]   root_out;

  assign in_a  = in_tdata[ID_W-1:0];
  assign in_b  = in_tdata[2*ID_W-1:ID_W];
  assign a_ext = EXT_W'(in_a);
  assign b_ext = EXT_W'(in_b);
  assign a_idx = a_ext[IDW-1:0];
  assign b_idx = b_ext[IDW-1:0];
  assign lim   = (EXT_W'(node_count_r) < MAX_L) ? EXT_W'(node_count_r) : MAX_L;
  assign in_err = !(a_ext < lim) || ((in_tuser == REQ_MERGE) && !(b_ext < lim));

  assign same = (ra_r == rb_r);
  assign a_gt = (size_a_r > sz_q_r);
  assign sum  = size_a_r + sz_q_r;

  // parent memory port control
  always_comb begin
    par_rd_en   = 1'b0;
    par_rd_addr = cur_r;
    if (cmd.accept) begin
      par_rd_en   = 1'b1;
      par_rd_addr = a_idx;
    end else if (cmd.walk_next) begin
      par_rd_en   = 1'b1;
      par_rd_addr = par_q_r;
    end else if (cmd.start_b) begin
      par_rd_en   = 1'b1;
      par_rd_addr = b_r;
    end else if (cmd.cmp_read) begin
      par_rd_en   = 1'b1;
      par_rd_addr = cur_r;
    end
    par_wr_en   = 1'b0;
    par_wr_addr = cur_r;
    par_wr_data = root_r;
    if (cmd.clr_step) begin
      par_wr_en   = 1'b1;
      par_wr_addr = clr_cnt_r;
      par_wr_data = clr_cnt_r;
    end else if (cmd.cmp_write) begin
      par_wr_en   = 1'b1;
      par_wr_addr = cur_r;
      par_wr_data = root_r;
    end else if (cmd.sz_fin && !same) begin
      par_wr_en   = 1'b1;
      par_wr_addr = a_gt ? rb_r : ra_r;
      par_wr_data = a_gt ? ra_r : rb_r;
    end
  end

  // size memory port control
  always_comb begin
    sz_rd_en   = cmd.sz_rd_a || cmd.sz_rd_b;
    sz_rd_addr = cmd.sz_rd_b ? rb_r : ra_r;
    sz_wr_en   = 1'b0;
    sz_wr_addr = clr_cnt_r;
    sz_wr_data = SIZE_W'(1);
    if (cmd.clr_step) begin
      sz_wr_en = 1'b1;
    end else if (cmd.sz_fin && !same) begin
      sz_wr_en   = 1'b1;
      sz_wr_addr = a_gt ? ra_r : rb_r;
      sz_wr_data = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (par_wr_en) begin
      par_mem[par_wr_addr] <= par_wr_data;
    end
    if (par_rd_en) begin
      par_q_r <= par_mem[par_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (sz_wr_en) begin
      sz_mem[sz_wr_addr] <= sz_wr_data;
    end
    if (sz_rd_en) begin
      sz_q_r <= sz_mem[sz_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
      clr_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        node_count_r <= cfg_data;
      end
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + IDW'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign root_out = ID_W'(EXT_W'(same ? ra_r : (a_gt ? ra_r : rb_r)));

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      is_merge_r   <= (in_tuser == REQ_MERGE);
      cur_r        <= a_idx;
      start_r      <= a_idx;
      b_r          <= b_idx;
      res_root_r   <= '0;
      res_size_r   <= '0;
      res_joined_r <= 1'b0;
      res_err_r    <= in_err;
    end
    if (cmd.walk_next) begin
      cur_r <= par_q_r;
    end
    if (cmd.walk_done) begin
      root_r <= cur_r;
      cur_r  <= start_r;
    end
    if (cmd.cmp_write) begin
      cur_r <= par_q_r;
    end
    if (cmd.start_b) begin
      cur_r   <= b_r;
      start_r <= b_r;
    end
    if (cmd.save_ra) begin
      ra_r <= root_r;
    end
    if (cmd.save_rb) begin
      rb_r <= root_r;
    end
    if (cmd.sz_rd_b) begin
      size_a_r <= sz_q_r;
    end
    if (cmd.sz_fin) begin
      res_root_r   <= root_out;
      res_size_r   <= same ? size_a_r : sum;
      res_joined_r <= !same;
      res_err_r    <= 1'b0;
    end
    if (cmd.out_load) begin
      out_data_r <= {1'b0, res_err_r, res_joined_r, res_size_r, res_root_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    sts.in_err      = in_err;
    sts.is_merge    = is_merge_r;
    sts.walk_root   = (par_q_r == cur_r);
    sts.cmp_at_root = (cur_r == root_r);
    sts.clr_last    = (clr_cnt_r == MAX_IDX);
    sts.out_free    = !out_valid_r || out_tready;
  end

endmodule

FILE: rtl/ufs_ctrl.sv
// Controller: clearing pass, root walk, path compression, merge and result sequencing.
module ufs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  ufs_pkg::ufs_sts_t sts,
  output ufs_pkg::ufs_cmd_t cmd
);
  import ufs_pkg::*;

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_WALK = 4'd2;
  localparam logic [3:0] ST_CCHK = 4'd3;
  localparam logic [3:0] ST_CWR  = 4'd4;
  localparam logic [3:0] ST_SZA  = 4'd5;
  localparam logic [3:0] ST_SZB  = 4'd6;
  localparam logic [3:0] ST_FIN  = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       phase_b_r, phase_b_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLR;
      phase_b_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      phase_b_r <= phase_b_nxt;
    end
  end

  always_comb begin
    cmd         = '0;
    state_nxt   = state_r;
    phase_b_nxt = phase_b_r;
    in_tready   = 1'b0;
    case (state_r)
      ST_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready   = 1'b1;
        phase_b_nxt = 1'b0;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.in_err ? ST_OUT : ST_WALK;
        end
      end
      ST_WALK: begin
        if (sts.walk_root) begin
          cmd.walk_done = 1'b1;
          state_nxt     = ST_CCHK;
        end else begin
          cmd.walk_next = 1'b1;
        end
      end
      ST_CCHK: begin
        if (sts.cmp_at_root) begin
          if (!phase_b_r && sts.is_merge) begin
            cmd.save_ra = 1'b1;
            cmd.start_b = 1'b1;
            phase_b_nxt = 1'b1;
            state_nxt   = ST_WALK;
          end else if (!phase_b_r) begin
            cmd.save_ra = 1'b1;
            cmd.save_rb = 1'b1;
            state_nxt   = ST_SZA;
          end else begin
            cmd.save_rb = 1'b1;
            state_nxt   = ST_SZA;
          end
        end else begin
          cmd.cmp_read = 1'b1;
          state_nxt    = ST_CWR;
        end
      end
      ST_CWR: begin
        cmd.cmp_write = 1'b1;
        state_nxt     = ST_CCHK;
      end
      ST_SZA: begin
        cmd.sz_rd_a = 1'b1;
        state_nxt   = ST_SZB;
      end
      ST_SZB: begin
        cmd.sz_rd_b = 1'b1;
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        cmd.sz_fin = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/union_find_with_sizes.sv
// Top level of the disjoint-set store with union by size and path compression.
//
//   channel  direction  handshake            payload
//   in_      slave      in_tvalid/in_tready  tuser req_type; tdata node_a, node_b
//   out_     master     out_tvalid/out_tready tdata root, comp_size, joined, error
//   cfg_     slave      cfg_valid/cfg_ready  cfg_data node_count
//
// One item at a time. A find walks the parent links from node_a to its root, then
// relinks each node on that path to the root; a merge does the same for node_b and
// links one root under the other by size, all through the parent memory; a bad id
// goes straight to the result. After reset a clearing pass initializes both memories;
// in_tready stays low meanwhile, cfg beats are taken at any time.
// A stalled out_ beat holds; the next in_ beat is still taken while it waits.
module union_find_with_sizes #(
  parameter int MAX_NODES = ufs_pkg::MAX_NODES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic                              in_tuser,   // [0] req_type
  input  logic [ufs_pkg::IN_DATA_W-1:0]     in_tdata,   // [9:0] node_a, [19:10] node_b
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ufs_pkg::OUT_DATA_W-1:0]    out_tdata,  // [9:0] root, [20:10] comp_size,
                                                        // [21] joined, [22] error
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ufs_pkg::CNT_W-1:0]         cfg_data
);
  import ufs_pkg::*;

  ufs_cmd_t cmd;
  ufs_sts_t sts;

  assign cfg_ready = 1'b1;

  ufs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ufs_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

endmodule
